/* src/stereo_rms_level_meter_macros.svh */
// assertion macros for the stereo rms level meter
`ifndef STEREO_RMS_LEVEL_METER_MACROS_SVH
`define STEREO_RMS_LEVEL_METER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SRLM_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srlm same-cycle check failed");

// next-cycle implication, checked outside reset
`define SRLM_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srlm next-cycle check failed");

`endif

/* src/srlm_pkg.sv */
// shared constants, types and helper functions of the level meter
package srlm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int IN_W        = 16;
  localparam int LEVEL_W     = 16;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int ENERGY_W    = 47;
  localparam int WIN_W       = 16;
  localparam int DIVISOR_W   = WIN_W + 1;
  localparam int RAD_W       = 48;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int SUM_W       = 64;
  localparam int COUNT_W     = 32;
  localparam int EDIV_CNT_W  = $clog2(ENERGY_W + 1);
  localparam int MDIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int ROOT_CNT_W  = $clog2(ROOT_W + 1);

  localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(2205);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = '1;

  typedef struct packed {
    logic load;
    logic clear;
    logic square;
    logic accum;
    logic div_start;
  } lane_ctl_t;

  typedef struct packed {
    logic clear;
    logic accum;
    logic start;
  } merge_ctl_t;

  typedef struct packed {
    logic               busy;
    logic               close;
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] mean;
    logic [COUNT_W-1:0] total;
  } merge_stat_t;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [IN_W-1:0] raw);
    logic [SAMPLE_BITS-1:0] v;
    v = raw[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
  endfunction

endpackage

/* src/srlm_lane.sv */
// one channel lane: magnitude, square, energy sum and energy / window divider
module srlm_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  srlm_pkg::lane_ctl_t             ctl,
  input  logic [srlm_pkg::IN_W-1:0]       sample,
  input  logic [srlm_pkg::DIVISOR_W-1:0]  divisor,
  output logic [srlm_pkg::SAMPLE_BITS-1:0] mag,
  output logic [srlm_pkg::ENERGY_W-1:0]   quotient,
  output logic                            busy
);
  import srlm_pkg::*;

  logic [SQ_W-1:0]       sq;
  logic [ENERGY_W-1:0]   energy;
  logic [ENERGY_W-1:0]   energy_sum;
  logic [ENERGY_W-1:0]   quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  rem_ge;
  logic [EDIV_CNT_W-1:0] cnt;

  assign energy_sum = energy + ENERGY_W'(sq);
  assign rem_sh     = {rem, quo[ENERGY_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, divisor};
  assign rem_diff   = rem_sh - {1'b0, divisor};
  assign quotient   = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag    <= '0;
      sq     <= '0;
      energy <= '0;
      quo    <= '0;
      rem    <= '0;
      cnt    <= '0;
      busy   <= 1'b0;
    end else begin
      if (ctl.load) begin
        mag <= magnitude(sample);
      end
      if (ctl.square) begin
        sq <= SQ_W'(mag) * SQ_W'(mag);
      end
      if (ctl.clear) begin
        energy <= '0;
      end else if (ctl.accum) begin
        energy <= ctl.div_start ? '0 : energy_sum;
      end
      // restoring divide, one quotient bit a cycle
      if (ctl.accum && ctl.div_start) begin
        quo  <= energy_sum;
        rem  <= '0;
        cnt  <= EDIV_CNT_W'(ENERGY_W);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[ENERGY_W-2:0], rem_ge};
        rem <= rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == EDIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/srlm_isqrt.sv */
// digit-by-digit integer square root, two radicand bits a cycle
module srlm_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [srlm_pkg::RAD_W-1:0]  radicand,
  output logic [srlm_pkg::ROOT_W-1:0] root,
  output logic                        busy
);
  import srlm_pkg::*;

  logic [RAD_W-1:0]      rad;
  logic [ROOT_W+1:0]     rem;
  logic [ROOT_W+3:0]     rem_sh;
  logic [ROOT_W+3:0]     trial;
  logic [ROOT_W+3:0]     diff;
  logic                  ge;
  logic [ROOT_CNT_W-1:0] cnt;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      rad  <= '0;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
      busy <= 1'b0;
    end else if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= ROOT_CNT_W'(ROOT_W);
      busy <= 1'b1;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == ROOT_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* src/srlm_merge.sv */
// merging stage: peak, window position, window rms, running sum and mean
module srlm_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  srlm_pkg::merge_ctl_t             ctl,
  input  logic [srlm_pkg::DIVISOR_W-1:0]   divisor,
  input  logic [srlm_pkg::SAMPLE_BITS-1:0] left_mag,
  input  logic [srlm_pkg::SAMPLE_BITS-1:0] right_mag,
  input  logic [srlm_pkg::ENERGY_W-1:0]    left_quo,
  input  logic [srlm_pkg::ENERGY_W-1:0]    right_quo,
  output srlm_pkg::merge_stat_t            stat
);
  import srlm_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_SQRT, M_UPDATE, M_DIVIDE} mstate_t;

  mstate_t               state;
  logic [WIN_W-1:0]      frame_position;
  logic [LEVEL_W-1:0]    peak;
  logic [LEVEL_W-1:0]    rms;
  logic [SUM_W-1:0]      rms_sum;
  logic [COUNT_W-1:0]    win_count;
  logic [LEVEL_W-1:0]    mean;
  logic [SUM_W-1:0]      dquo;
  logic [COUNT_W-1:0]    drem;
  logic [MDIV_CNT_W-1:0] dcnt;

  logic [DIVISOR_W-1:0] count_next;
  logic                 close_now;
  logic [ENERGY_W:0]    quo_sum;
  logic [RAD_W-1:0]     radicand;
  logic [ROOT_W-1:0]    root;
  logic                 sqrt_busy;
  logic [LEVEL_W-1:0]   level_l;
  logic [LEVEL_W-1:0]   level_r;
  logic [LEVEL_W-1:0]   peak_lr;
  logic [LEVEL_W-1:0]   peak_next;
  logic [LEVEL_W-1:0]   rms_new;
  logic [SUM_W-1:0]     sum_new;
  logic [COUNT_W-1:0]   count_inc;
  logic [COUNT_W:0]     drem_sh;
  logic [COUNT_W:0]     drem_diff;
  logic                 dge;

  assign count_next = {1'b0, frame_position} + 1'b1;
  assign close_now  = count_next >= divisor;
  assign quo_sum    = {1'b0, left_quo} + {1'b0, right_quo};
  assign radicand   = RAD_W'(quo_sum[ENERGY_W:1]);

  assign level_l   = sat_level(SUM_W'(left_mag));
  assign level_r   = sat_level(SUM_W'(right_mag));
  assign peak_lr   = (level_l > level_r) ? level_l : level_r;
  assign peak_next = (peak_lr > peak) ? peak_lr : peak;

  assign rms_new   = sat_level(SUM_W'(root));
  assign sum_new   = rms_sum + SUM_W'(rms_new);
  assign count_inc = win_count + 1'b1;

  assign drem_sh   = {drem, dquo[SUM_W-1]};
  assign dge       = drem_sh >= {1'b0, win_count};
  assign drem_diff = drem_sh - {1'b0, win_count};

  srlm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.start),
    .radicand (radicand),
    .root     (root),
    .busy     (sqrt_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= M_IDLE;
      frame_position <= '0;
      peak           <= '0;
      rms            <= '0;
      rms_sum        <= '0;
      win_count      <= '0;
      mean           <= '0;
      dquo           <= '0;
      drem           <= '0;
      dcnt           <= '0;
    end else begin
      if (ctl.clear) begin
        frame_position <= '0;
        peak           <= '0;
        rms_sum        <= '0;
        win_count      <= '0;
        mean           <= '0;
      end else if (ctl.accum) begin
        peak           <= peak_next;
        frame_position <= close_now ? '0 : count_next[WIN_W-1:0];
      end
      case (state)
        M_IDLE: begin
          if (ctl.start) begin
            state <= M_SQRT;
          end
        end
        M_SQRT: begin
          if (!sqrt_busy) begin
            state <= M_UPDATE;
          end
        end
        M_UPDATE: begin
          rms       <= rms_new;
          rms_sum   <= sum_new;
          win_count <= count_inc;
          // no windows after wrap gives a zero mean
          if (count_inc == '0) begin
            mean  <= '0;
            state <= M_IDLE;
          end else begin
            dquo  <= sum_new;
            drem  <= '0;
            dcnt  <= MDIV_CNT_W'(SUM_W);
            state <= M_DIVIDE;
          end
        end
        M_DIVIDE: begin
          if (dcnt != '0) begin
            dquo <= {dquo[SUM_W-2:0], dge};
            drem <= dge ? drem_diff[COUNT_W-1:0] : drem_sh[COUNT_W-1:0];
            dcnt <= dcnt - 1'b1;
          end else begin
            mean  <= sat_level(dquo);
            state <= M_IDLE;
          end
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  assign stat.busy  = state != M_IDLE;
  assign stat.close = close_now;
  assign stat.rms   = rms;
  assign stat.peak  = peak;
  assign stat.mean  = mean;
  assign stat.total = win_count;

endmodule

/* src/stereo_rms_level_meter.sv */
// top level of the stereo rms and peak level meter
//
//   channel  signals                                       beat taken when
//   -------  --------------------------------------------  ----------------------------
//   in       left_sample right_sample new_track            in_valid && in_ready
//   out      window_done window_rms peak_level             out_valid && out_ready
//            average_level window_total
//   cfg      cfg_write_data                                cfg_write_enable
//
// a frame that does not close a window passes through capture, square, accumulate and hand-off
// a closing frame adds per-lane energy division, square root, sum update and mean division
// before hand-off; the mean division is skipped when the count wraps
// the per-lane energy division and the mean division are bit-serial
// a result waits in the output register while the next beat is taken
// synchronous reset clears all statistics and loads a window of 2205 frames
`include "stereo_rms_level_meter_macros.svh"

module stereo_rms_level_meter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [srlm_pkg::WIN_W-1:0]         cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [srlm_pkg::IN_W-1:0]   left_sample,
  input  logic signed [srlm_pkg::IN_W-1:0]   right_sample,
  input  logic                               new_track,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               window_done,
  output logic [srlm_pkg::LEVEL_W-1:0]       window_rms,
  output logic [srlm_pkg::LEVEL_W-1:0]       peak_level,
  output logic [srlm_pkg::LEVEL_W-1:0]       average_level,
  output logic [srlm_pkg::COUNT_W-1:0]       window_total
);
  import srlm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQUARE, S_ACCUM, S_LANE_DIV, S_MERGE, S_DELIVER
  } state_t;

  state_t               state;
  logic                 closing;
  logic [WIN_W-1:0]     window_frames;
  logic [DIVISOR_W-1:0] divisor;
  logic                 accept;
  lane_ctl_t            lane_ctl;
  merge_ctl_t           merge_ctl;
  merge_stat_t          merge_stat;
  logic [SAMPLE_BITS-1:0] left_mag;
  logic [SAMPLE_BITS-1:0] right_mag;
  logic [ENERGY_W-1:0]  left_quo;
  logic [ENERGY_W-1:0]  right_quo;
  logic                 left_busy;
  logic                 right_busy;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  // zero window length stands for 65536 frames
  assign divisor = (window_frames == '0) ? {1'b1, {WIN_W{1'b0}}} : {1'b0, window_frames};

  always_comb begin
    lane_ctl.load      = accept;
    lane_ctl.clear     = accept && new_track;
    lane_ctl.square    = state == S_SQUARE;
    lane_ctl.accum     = state == S_ACCUM;
    lane_ctl.div_start = (state == S_ACCUM) && merge_stat.close;
    merge_ctl.clear    = accept && new_track;
    merge_ctl.accum    = state == S_ACCUM;
    merge_ctl.start    = (state == S_LANE_DIV) && !left_busy && !right_busy;
  end

  srlm_lane u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .sample   (left_sample),
    .divisor  (divisor),
    .mag      (left_mag),
    .quotient (left_quo),
    .busy     (left_busy)
  );

  srlm_lane u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .sample   (right_sample),
    .divisor  (divisor),
    .mag      (right_mag),
    .quotient (right_quo),
    .busy     (right_busy)
  );

  srlm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (merge_ctl),
    .divisor   (divisor),
    .left_mag  (left_mag),
    .right_mag (right_mag),
    .left_quo  (left_quo),
    .right_quo (right_quo),
    .stat      (merge_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_frames <= WINDOW_RESET;
      state         <= S_IDLE;
      closing       <= 1'b0;
      out_valid     <= 1'b0;
      window_done   <= 1'b0;
      window_rms    <= '0;
      peak_level    <= '0;
      average_level <= '0;
      window_total  <= '0;
    end else begin
      if (cfg_write_enable) begin
        window_frames <= cfg_write_data;
      end
      if (out_valid && out_ready && state != S_DELIVER) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          closing <= merge_stat.close;
          state   <= merge_stat.close ? S_LANE_DIV : S_DELIVER;
        end
        S_LANE_DIV: begin
          if (!left_busy && !right_busy) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (!merge_stat.busy) begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (!out_valid || out_ready) begin
            window_done   <= closing;
            window_rms    <= closing ? merge_stat.rms : '0;
            peak_level    <= merge_stat.peak;
            average_level <= merge_stat.mean;
            window_total  <= merge_stat.total;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SRLM_NEXT(a_merge_runs_after_start, merge_ctl.start, merge_stat.busy)
  `SRLM_IMPLIES(a_lane_div_only_on_close, state == S_LANE_DIV, closing)
  `SRLM_IMPLIES(a_idle_units_quiet, in_ready, !left_busy && !right_busy && !merge_stat.busy)
  `SRLM_IMPLIES(a_open_window_no_rms, out_valid && !window_done, window_rms == '0)

endmodule
